@@ design/bust_pkg.sv @@
// Shared types and constants for the bounded unordered set table.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package bust_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef logic [1:0]        t_req_type;
    typedef logic [1:0]        t_status;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DATA_W-1:0] t_data;

    localparam t_req_type REQ_LOOKUP = 2'd0;
    localparam t_req_type REQ_INSERT = 2'd1;
    localparam t_req_type REQ_DELETE = 2'd2;

    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_MISSING = 2'd2;

    localparam t_cnt MAX_COUNT = t_cnt'(MAX_ENTRIES);

    typedef struct packed {
        logic  cmp;
        logic  ins;
        logic  del;
        t_data value;
        t_cnt  count;
        t_data last;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ design/bust_if.sv @@
// Handshake interfaces for the request and response channels of the set table.
// Depends on bust_pkg for field types.
`default_nettype none

interface bust_req_if;
    logic                            valid;
    logic                            ready;
    bust_pkg::t_req_type             req_type;
    logic signed [bust_pkg::DATA_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface bust_rsp_if;
    logic                    valid;
    logic                    ready;
    logic                    found;
    bust_pkg::t_cnt          position;
    bust_pkg::t_cnt          count;
    bust_pkg::t_status       status;

    modport source (output valid, output found, output position, output count,
                    output status, input ready);
    modport sink   (input valid, input found, input position, input count,
                    input status, output ready);
endinterface

`default_nettype wire

@@ design/bounded_unordered_set_table_unit.sv @@
// Top level of the bounded unordered set table: request/response control and the cell row.
// Depends on bust_pkg, bust_req_if, bust_rsp_if and bust_cell.
`default_nettype none

// Each request passes through a compare state, in which every cell compares its entry with the
// request word, and an update state, in which the hit is encoded and the table and count are updated.
// A new request is taken in the update state of the previous one while the response side
// keeps up; the result waits in an output
// register and stalls only the update state. A delete moves the last entry into the freed
// slot, so positions of other entries can change. The capacity register may be written
// only while no request is in flight; values above 64 act as 64.
module bounded_unordered_set_table_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    bust_req_if.sink                   i_req,
    bust_rsp_if.source                 o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire bust_pkg::t_cnt        i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    bust_pkg::t_cnt                  r_count;
    bust_pkg::t_cnt                  n_count;
    bust_pkg::t_cnt                  r_cap;
    bust_pkg::t_req_type             r_kind;
    bust_pkg::t_data                 r_value;
    bust_pkg::t_data                 r_last;
    bust_pkg::t_data                 n_last;
    logic                            r_out_valid;
    logic                            r_out_found;
    bust_pkg::t_cnt                  r_out_pos;
    bust_pkg::t_cnt                  r_out_count;
    bust_pkg::t_status               r_out_status;

    logic [bust_pkg::MAX_ENTRIES-1:0] w_match;
    bust_pkg::t_data                  w_last [bust_pkg::MAX_ENTRIES];
    bust_pkg::t_cell_ctl              w_ctl;
    logic                             w_accept;
    logic                             w_upd_go;
    logic                             w_hit;
    bust_pkg::t_idx                   w_enc;
    bust_pkg::t_cnt                   w_pos;
    bust_pkg::t_cnt                   w_cap;
    logic                             w_full;
    logic                             w_ins_go;
    logic                             w_del_go;
    bust_pkg::t_status                w_status;

    assign w_upd_go    = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_state == S_IDLE) || w_upd_go;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        w_enc = '0;
        for (int i = 0; i < bust_pkg::MAX_ENTRIES; i++) begin
            if (w_match[i]) begin
                w_enc = w_enc | bust_pkg::t_idx'(i);
            end
        end
        n_last = '0;
        for (int i = 0; i < bust_pkg::MAX_ENTRIES; i++) begin
            n_last = n_last | w_last[i];
        end
    end

    assign w_hit  = |w_match;
    assign w_pos  = w_hit ? bust_pkg::t_cnt'(w_enc) : r_count;
    assign w_cap  = (r_cap > bust_pkg::MAX_COUNT) ? bust_pkg::MAX_COUNT : r_cap;
    assign w_full = r_count >= w_cap;

    always_comb begin
        w_ins_go = 1'b0;
        w_del_go = 1'b0;
        w_status = bust_pkg::ST_DONE;
        case (r_kind)
            bust_pkg::REQ_INSERT: begin
                if (w_full) begin
                    w_status = bust_pkg::ST_FULL;
                end else begin
                    w_ins_go = w_upd_go && !w_hit;
                end
            end
            bust_pkg::REQ_DELETE: begin
                if (w_hit) begin
                    w_del_go = w_upd_go;
                end else begin
                    w_status = bust_pkg::ST_MISSING;
                end
            end
            default: begin
                w_status = bust_pkg::ST_DONE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ins_go) begin
            n_count = r_count + 1'b1;
        end else if (w_del_go) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_upd_go) begin
                    n_state = w_accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_ctl.cmp   = (r_state == S_CMP);
    assign w_ctl.ins   = w_ins_go;
    assign w_ctl.del   = w_del_go;
    assign w_ctl.value = r_value;
    assign w_ctl.count = r_count;
    assign w_ctl.last  = r_last;

    for (genvar g = 0; g < bust_pkg::MAX_ENTRIES; g++) begin : g_cell
        bust_cell u_cell (
            .i_clk   (i_clk),
            .i_index (bust_pkg::t_idx'(g)),
            .i_ctl   (w_ctl),
            .o_match (w_match[g]),
            .o_last  (w_last[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= bust_pkg::MAX_COUNT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (w_upd_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_req.req_type;
            r_value <= bust_pkg::t_data'(i_req.value);
        end
        if (r_state == S_CMP) begin
            r_last <= n_last;
        end
        if (w_upd_go) begin
            r_out_found  <= w_hit;
            r_out_pos    <= w_pos;
            r_out_count  <= n_count;
            r_out_status <= w_status;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_out_found;
    assign o_rsp.position = r_out_pos;
    assign o_rsp.count    = r_out_count;
    assign o_rsp.status   = r_out_status;

endmodule

`default_nettype wire

@@ design/bust_cell.sv @@
// One slot of the set table: holds an entry, compares it and takes writes.
// Depends on bust_pkg for the control struct and widths.
`default_nettype none

module bust_cell (
    input  wire logic                i_clk,
    input  wire bust_pkg::t_idx      i_index,
    input  wire bust_pkg::t_cell_ctl i_ctl,
    output logic                     o_match,
    output bust_pkg::t_data          o_last
);

    bust_pkg::t_data r_entry;
    bust_pkg::t_data n_entry;
    logic            r_match;
    logic            n_match;
    bust_pkg::t_cnt  w_index;
    logic            w_live;

    assign w_index = bust_pkg::t_cnt'(i_index);
    assign w_live  = w_index < i_ctl.count;

    always_comb begin
        n_entry = r_entry;
        n_match = r_match;
        if (i_ctl.cmp) begin
            n_match = w_live && (r_entry == i_ctl.value);
        end
        if (i_ctl.ins && (w_index == i_ctl.count)) begin
            n_entry = i_ctl.value;
        end else if (i_ctl.del && r_match) begin
            n_entry = i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= n_match;
    end

    assign o_match = r_match;
    assign o_last  = (w_index == (i_ctl.count - 1'b1)) ? r_entry : '0;

endmodule

`default_nettype wire

@@ tb/tb_bounded_unordered_set_table_unit.sv @@
// Self-checking testbench for bounded_unordered_set_table_unit.
// Depends on bust_pkg and the bust_req_if / bust_rsp_if interfaces; predicts every result
// with its own copy of the table and checks each response word as it leaves the block.
module tb_bounded_unordered_set_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bust_pkg::*;

    localparam t_req_type REQ_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 60;
    localparam int POOL_SIZE   = 128;

    typedef struct packed {
        logic    found;
        t_cnt    position;
        t_cnt    count;
        t_status status;
    } set_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    t_cnt cfg_data;

    bust_req_if req_if ();
    bust_rsp_if rsp_if ();

    bounded_unordered_set_table_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    t_data       set_table [MAX_ENTRIES];
    int          set_count;
    int          capacity;
    set_result_t pending_results [$];
    set_result_t oldest;
    t_data       value_pool [POOL_SIZE];
    int          err_count = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;
    bit          long_stall_req = 1'b0;

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    function automatic set_result_t apply_set_request(input t_req_type kind, input t_data val);
        set_result_t r;
        int          eff_cap;
        int          pos;
        eff_cap = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
        pos = set_count;
        for (int i = 0; i < set_count; i++) begin
            if (set_table[i] == val) begin
                pos = i;
                break;
            end
        end
        r.found    = (pos < set_count);
        r.position = t_cnt'(pos);
        r.status   = ST_DONE;
        case (kind)
            REQ_INSERT: begin
                if (set_count >= eff_cap) begin
                    r.status = ST_FULL;
                end else if (!r.found) begin
                    set_table[set_count] = val;
                    set_count++;
                end
            end
            REQ_DELETE: begin
                if (r.found) begin
                    set_table[pos] = set_table[set_count - 1];
                    set_count--;
                end else begin
                    r.status = ST_MISSING;
                end
            end
            default: begin
            end
        endcase
        r.count = t_cnt'(set_count);
        return r;
    endfunction

    // Response side: random back-pressure bursts, plus one long hold-off on request.
    initial begin : rsp_ready_drive
        int stall_left;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                stall_left = LONG_STALL;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8);
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("response word with no request outstanding");
            end else begin
                oldest = pending_results.pop_front();
                if (rsp_if.found !== oldest.found)
                    report_mismatch($sformatf("found %b, expected %b",
                                              rsp_if.found, oldest.found));
                if (rsp_if.position !== oldest.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              rsp_if.position, oldest.position));
                if (rsp_if.count !== oldest.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              rsp_if.count, oldest.count));
                if (rsp_if.status !== oldest.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_if.status, oldest.status));
            end
        end
    end

    // Called and returning at a rising edge; the word is driven on a falling edge.
    task automatic send_word(input t_req_type kind, input t_data val);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= kind;
        req_if.value    <= val;
        do @(posedge clk); while (!req_if.ready);
        pending_results.push_back(apply_set_request(kind, val));
    endtask

    task automatic drain_results();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(input int cap);
        drain_results();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= t_cnt'(cap);
        @(negedge clk);
        cfg_we   <= 1'b0;
        capacity = cap;
        @(posedge clk);
    endtask

    task automatic run_random_mix(input int n, input int ins_pct, input int del_pct,
                                  input int pool_sz);
        int        roll;
        t_req_type kind;
        t_data     val;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                kind = REQ_INSERT;
            else if (roll < ins_pct + del_pct)
                kind = REQ_DELETE;
            else if (roll < 97)
                kind = REQ_LOOKUP;
            else
                kind = REQ_UNKNOWN;
            if ($urandom_range(0, 9) == 0)
                val = $urandom();
            else
                val = value_pool[$urandom_range(0, pool_sz - 1)];
            send_word(kind, val);
        end
    endtask

    task automatic test_directed_ops();
        send_word(REQ_LOOKUP, 32'h0000_0000);
        send_word(REQ_DELETE, 32'h0000_0000);
        send_word(REQ_INSERT, 32'h8000_0000);
        send_word(REQ_INSERT, 32'h7FFF_FFFF);
        send_word(REQ_INSERT, 32'h0000_0000);
        send_word(REQ_INSERT, 32'hFFFF_FFFF);
        send_word(REQ_INSERT, 32'h0000_0000);
        send_word(REQ_LOOKUP, 32'h7FFF_FFFF);
        send_word(REQ_UNKNOWN, 32'hFFFF_FFFF);
        send_word(REQ_DELETE, 32'h8000_0000);
        send_word(REQ_LOOKUP, 32'hFFFF_FFFF);
        send_word(REQ_DELETE, 32'h0000_0005);
        send_word(REQ_INSERT, 32'hAAAA_AAAA);
        send_word(REQ_INSERT, 32'h5555_5555);
        send_word(REQ_DELETE, 32'h5555_5555);
    endtask

    task automatic test_capacity_edges();
        set_capacity(1);
        send_word(REQ_INSERT, 32'h7FFF_FFFF);
        send_word(REQ_INSERT, 32'h1234_5678);
        send_word(REQ_LOOKUP, 32'h1234_5678);
        set_capacity(0);
        send_word(REQ_INSERT, 32'h0F0F_0F0F);
        send_word(REQ_DELETE, 32'hAAAA_AAAA);
        set_capacity(127);
        send_word(REQ_INSERT, 32'h0F0F_0F0F);
    endtask

    task automatic test_random_fill();
        run_random_mix(300, 60, 15, 96);
    endtask

    task automatic test_random_churn();
        set_capacity(64);
        run_random_mix(300, 40, 40, 64);
    endtask

    task automatic test_back_pressure();
        long_stall_req = 1'b1;
        run_random_mix(30, 40, 30, 96);
    endtask

    task automatic test_small_capacity();
        while (set_count > 0) send_word(REQ_DELETE, set_table[0]);
        set_capacity(1);
        run_random_mix(150, 45, 30, 6);
        set_capacity(8);
        run_random_mix(150, 45, 25, 16);
    endtask

    task automatic test_shrink_below_count();
        set_capacity(64);
        run_random_mix(120, 85, 5, POOL_SIZE);
        set_capacity(10);
        run_random_mix(150, 35, 45, POOL_SIZE);
    endtask

    task automatic test_streaming();
        set_capacity(100);
        idle_on = 1'b0;
        run_random_mix(150, 50, 30, 96);
    endtask

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        req_if.valid    = 1'b0;
        req_if.req_type = REQ_LOOKUP;
        req_if.value    = '0;
        set_count       = 0;
        capacity        = MAX_ENTRIES;
        foreach (value_pool[i]) value_pool[i] = $urandom();
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_capacity_edges();
        test_random_fill();
        test_random_churn();
        test_back_pressure();
        test_small_capacity();
        test_shrink_below_count();
        test_streaming();
        drain_results();

        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
